FILE: src/opus_id_header_parser_macros.svh
// ----------------------------------------------------------------------------
// Opus ID header parser assertion macros
// Shared concurrent assertion forms for the parser and its result queue.
// ----------------------------------------------------------------------------
`ifndef OPUS_ID_HEADER_PARSER_MACROS_SVH
`define OPUS_ID_HEADER_PARSER_MACROS_SVH

// same-cycle implication
`define OIHP_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define OIHP_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: src/opus_ihp_pkg.sv
// ----------------------------------------------------------------------------
// Opus ID header parser package
// Status codes, result record and fixed header constants.
// ----------------------------------------------------------------------------
package opus_ihp_pkg;

   localparam logic [15:0] MIN_HEADER_LEN = 16'd19;
   localparam logic [15:0] MAP_HEADER_LEN = MIN_HEADER_LEN + 16'd2;
   localparam logic [7:0]  MAJOR_MASK     = 8'd240;
   localparam logic [7:0]  MAP_UNUSED     = 8'd255;
   localparam logic [8:0]  MAX_SUM        = 9'd255;

   typedef enum logic [3:0] {
      ST_OK       = 4'd0,
      ST_TRUNC    = 4'd1,
      ST_MAGIC    = 4'd2,
      ST_VERSION  = 4'd3,
      ST_ZERO_CH  = 4'd4,
      ST_FAM0_CH  = 4'd5,
      ST_STREAMS  = 4'd6,
      ST_COUPLED  = 4'd7,
      ST_MAP      = 4'd8,
      ST_TRAILING = 4'd9
   } status_type;

   typedef enum logic {
      KIND_MAP     = 1'b0,
      KIND_SUMMARY = 1'b1
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      status_type  status;
      logic [7:0]  version;
      logic [7:0]  channels;
      logic [15:0] preskip;
      logic [31:0] sample_rate;
      logic [15:0] gain;
      logic [7:0]  mapping_family;
      logic [7:0]  stream_count;
      logic [7:0]  coupled_count;
      logic [7:0]  map_index;
      logic [7:0]  map_value;
   } result_type;

   // up to two results per accepted byte, first in order first
   typedef struct packed {
      logic       first_valid;
      logic       second_valid;
      result_type first;
      result_type second;
   } push_type;

   function automatic logic [7:0] magic_byte(input logic [2:0] idx);
      logic [7:0] val;
      case (idx)
         3'd0:    val = 8'h4F; // O
         3'd1:    val = 8'h70; // p
         3'd2:    val = 8'h75; // u
         3'd3:    val = 8'h73; // s
         3'd4:    val = 8'h48; // H
         3'd5:    val = 8'h65; // e
         3'd6:    val = 8'h61; // a
         3'd7:    val = 8'h64; // d
         default: val = 8'h00;
      endcase
      return val;
   endfunction

endpackage

FILE: src/opus_ihp_fifo.sv
// ----------------------------------------------------------------------------
// Opus ID header parser result queue
// Small register queue that takes up to two results per cycle, emits one.
// ----------------------------------------------------------------------------
`include "opus_id_header_parser_macros.svh"

module opus_ihp_fifo #(
   parameter int DEPTH = 4
) (
   input  logic                    clock,
   input  logic                    reset,
   input  opus_ihp_pkg::push_type  push,
   input  logic                    pop,
   output opus_ihp_pkg::result_type head,
   output logic                    not_empty,
   output logic                    room_two
);
   import opus_ihp_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   result_type      mem_ff [DEPTH];
   logic [PW-1:0]   wr_ptr_ff;
   logic [PW-1:0]   wr_ptr_in;
   logic [PW-1:0]   wr_ptr_next;
   logic [PW-1:0]   rd_ptr_ff;
   logic [PW-1:0]   rd_ptr_in;
   logic [CW-1:0]   count_ff;
   logic [CW-1:0]   count_in;

   function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
      logic [PW-1:0] r;
      if (p == PW'(DEPTH - 1)) begin
         r = '0;
      end else begin
         r = p + 1'b1;
      end
      return r;
   endfunction

   assign wr_ptr_next = ptr_inc(wr_ptr_ff);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      if (push.first_valid && push.second_valid) begin
         wr_ptr_in = ptr_inc(wr_ptr_next);
      end else if (push.first_valid) begin
         wr_ptr_in = wr_ptr_next;
      end
      rd_ptr_in = pop ? ptr_inc(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + CW'(push.first_valid) + CW'(push.second_valid)
                  - CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.first_valid) begin
         mem_ff[wr_ptr_ff] <= push.first;
      end
      if (push.second_valid) begin
         mem_ff[wr_ptr_next] <= push.second;
      end
   end

   assign head      = mem_ff[rd_ptr_ff];
   assign not_empty = (count_ff != '0);
   assign room_two  = (count_ff <= CW'(DEPTH - 2));

   `OIHP_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= CW'(DEPTH),
      "result queue overfilled")
   `OIHP_ASSERT_NOW(a_push_order, clock, reset, push.second_valid,
      push.first_valid, "second result pushed without first")
   `OIHP_ASSERT_NEXT(a_pop_count, clock, reset, pop && !push.first_valid,
      count_ff == $past(count_ff) - CW'(1), "pop did not drop count")

endmodule

FILE: src/opus_id_header_parser.sv
// A byte's results reach rsp_* in the cycle after it is accepted when the
// result queue is empty. One byte per cycle while req_stall is low; a byte
// that yields a map entry and the summary pushes both, and the queue emits
// them one at a time. req_stall rises while the queue lacks room for two
// results. Synchronous reset clears parse state and queue; no clearing pass.
// ----------------------------------------------------------------------------
// Opus ID header parser
// Byte-serial parser for the Opus identification header with map entries.
// ----------------------------------------------------------------------------
`include "opus_id_header_parser_macros.svh"

module opus_id_header_parser #(
   parameter int RSP_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_kind,
   output logic [3:0]  rsp_status,
   output logic [7:0]  rsp_version,
   output logic [7:0]  rsp_channels,
   output logic [15:0] rsp_preskip,
   output logic [31:0] rsp_sample_rate,
   output logic [15:0] rsp_gain,
   output logic [7:0]  rsp_mapping_family,
   output logic [7:0]  rsp_stream_count,
   output logic [7:0]  rsp_coupled_count,
   output logic [7:0]  rsp_map_index,
   output logic [7:0]  rsp_map_value
);
   import opus_ihp_pkg::*;

   logic [15:0] pos_ff, pos_in;
   status_type  err_ff, err_in;
   logic [7:0]  version_ff, version_in;
   logic [7:0]  channel_ff, channel_in;
   logic [15:0] preskip_ff, preskip_in;
   logic [31:0] rate_ff, rate_in;
   logic [15:0] gain_ff, gain_in;
   logic [7:0]  family_ff, family_in;
   logic [7:0]  streams_ff, streams_in;
   logic [7:0]  coupled_ff, coupled_in;
   logic [7:0]  map_cnt_ff, map_cnt_in;

   logic        req_acc;
   logic        map_emit;
   logic        done;
   logic [8:0]  limit;
   status_type  sum_status;
   result_type  map_res;
   result_type  sum_res;
   push_type    push;
   result_type  head;
   logic        not_empty;
   logic        room_two;

   assign req_acc = req_valid && !req_stall;

   always_comb begin
      pos_in     = pos_ff;
      err_in     = err_ff;
      version_in = version_ff;
      channel_in = channel_ff;
      preskip_in = preskip_ff;
      rate_in    = rate_ff;
      gain_in    = gain_ff;
      family_in  = family_ff;
      streams_in = streams_ff;
      coupled_in = coupled_ff;
      map_cnt_in = map_cnt_ff;
      map_emit   = 1'b0;
      done       = 1'b0;
      sum_status = ST_OK;
      limit      = {1'b0, streams_ff} + {1'b0, coupled_ff};
      map_res    = '0;
      sum_res    = '0;
      push       = '0;

      if (req_acc) begin
         if (err_ff == ST_OK) begin
            if (pos_ff < 16'd8) begin
               if (req_data_byte != magic_byte(pos_ff[2:0])) begin
                  err_in = ST_MAGIC;
               end
            end else if (pos_ff == 16'd8) begin
               version_in = req_data_byte;
               if ((req_data_byte & MAJOR_MASK) != 8'd0) begin
                  err_in = ST_VERSION;
               end
            end else if (pos_ff == 16'd9) begin
               channel_in = req_data_byte;
               if (req_data_byte == 8'd0) begin
                  err_in = ST_ZERO_CH;
               end
            end else if (pos_ff < 16'd12) begin
               if (pos_ff[0]) begin
                  preskip_in[15:8] = req_data_byte;
               end else begin
                  preskip_in[7:0] = req_data_byte;
               end
            end else if (pos_ff < 16'd16) begin
               case (pos_ff[1:0])
                  2'd0:    rate_in[7:0]   = req_data_byte;
                  2'd1:    rate_in[15:8]  = req_data_byte;
                  2'd2:    rate_in[23:16] = req_data_byte;
                  2'd3:    rate_in[31:24] = req_data_byte;
                  default: rate_in        = rate_ff;
               endcase
            end else if (pos_ff < 16'd18) begin
               if (pos_ff[0]) begin
                  gain_in[15:8] = req_data_byte;
               end else begin
                  gain_in[7:0] = req_data_byte;
               end
            end else if (pos_ff == 16'd18) begin
               family_in = req_data_byte;
               if (req_data_byte == 8'd0) begin
                  if (channel_ff > 8'd2) begin
                     err_in = ST_FAM0_CH;
                  end
                  streams_in = 8'd1;
                  coupled_in = (channel_ff > 8'd1) ? 8'd1 : 8'd0;
               end
            end else if (family_ff == 8'd0) begin
               if (version_ff == 8'd0 || version_ff == 8'd1) begin
                  err_in = ST_TRAILING;
               end
            end else if (pos_ff == 16'd19) begin
               streams_in = req_data_byte;
               if (req_data_byte == 8'd0) begin
                  err_in = ST_STREAMS;
               end
            end else if (pos_ff == 16'd20) begin
               coupled_in = req_data_byte;
               if (req_data_byte > streams_ff ||
                   ({1'b0, req_data_byte} + {1'b0, streams_ff}) > MAX_SUM) begin
                  err_in = ST_COUPLED;
               end
            end else if (map_cnt_ff < channel_ff) begin
               if ({1'b0, req_data_byte} > limit && req_data_byte != MAP_UNUSED) begin
                  err_in = ST_MAP;
               end
               map_emit   = 1'b1;
               map_cnt_in = map_cnt_ff + 8'd1;
            end else begin
               if (version_ff == 8'd0 || version_ff == 8'd1) begin
                  err_in = ST_TRAILING;
               end
            end
         end

         // saturate the byte counter on very long packets
         if (pos_ff != 16'hFFFF) begin
            pos_in = pos_ff + 16'd1;
         end

         done = (pos_in >= MIN_HEADER_LEN) &&
                (family_in == 8'd0 ||
                 (pos_in >= MAP_HEADER_LEN && map_cnt_in == channel_in));
         sum_status = (err_in == ST_OK && !done) ? ST_TRUNC : err_in;

         map_res.kind           = KIND_MAP;
         map_res.status         = err_in;
         map_res.version        = version_in;
         map_res.channels       = channel_in;
         map_res.preskip        = preskip_in;
         map_res.sample_rate    = rate_in;
         map_res.gain           = gain_in;
         map_res.mapping_family = family_in;
         map_res.stream_count   = streams_in;
         map_res.coupled_count  = coupled_in;
         map_res.map_index      = map_cnt_ff;
         map_res.map_value      = req_data_byte;

         sum_res           = map_res;
         sum_res.kind      = KIND_SUMMARY;
         sum_res.status    = sum_status;
         sum_res.map_index = 8'd0;
         sum_res.map_value = 8'd0;

         if (map_emit) begin
            push.first_valid  = 1'b1;
            push.first        = map_res;
            push.second_valid = req_last_byte;
            push.second       = sum_res;
         end else begin
            push.first_valid = req_last_byte;
            push.first       = sum_res;
         end

         // clear for the next packet
         if (req_last_byte) begin
            pos_in     = '0;
            err_in     = ST_OK;
            version_in = '0;
            channel_in = '0;
            preskip_in = '0;
            rate_in    = '0;
            gain_in    = '0;
            family_in  = '0;
            streams_in = '0;
            coupled_in = '0;
            map_cnt_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= '0;
         err_ff     <= ST_OK;
         version_ff <= '0;
         channel_ff <= '0;
         preskip_ff <= '0;
         rate_ff    <= '0;
         gain_ff    <= '0;
         family_ff  <= '0;
         streams_ff <= '0;
         coupled_ff <= '0;
         map_cnt_ff <= '0;
      end else begin
         pos_ff     <= pos_in;
         err_ff     <= err_in;
         version_ff <= version_in;
         channel_ff <= channel_in;
         preskip_ff <= preskip_in;
         rate_ff    <= rate_in;
         gain_ff    <= gain_in;
         family_ff  <= family_in;
         streams_ff <= streams_in;
         coupled_ff <= coupled_in;
         map_cnt_ff <= map_cnt_in;
      end
   end

   opus_ihp_fifo #(
      .DEPTH (RSP_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .pop       (rsp_valid && !rsp_stall),
      .head      (head),
      .not_empty (not_empty),
      .room_two  (room_two)
   );

   assign req_stall          = !room_two;
   assign rsp_valid          = not_empty;
   assign rsp_kind           = head.kind;
   assign rsp_status         = head.status;
   assign rsp_version        = head.version;
   assign rsp_channels       = head.channels;
   assign rsp_preskip        = head.preskip;
   assign rsp_sample_rate    = head.sample_rate;
   assign rsp_gain           = head.gain;
   assign rsp_mapping_family = head.mapping_family;
   assign rsp_stream_count   = head.stream_count;
   assign rsp_coupled_count  = head.coupled_count;
   assign rsp_map_index      = head.map_index;
   assign rsp_map_value      = head.map_value;

   `OIHP_ASSERT_NEXT(a_last_clears, clock, reset, req_acc && req_last_byte,
      pos_ff == 16'd0 && err_ff == ST_OK, "state not cleared after last byte")
   `OIHP_ASSERT_NEXT(a_err_sticky, clock, reset,
      err_ff != ST_OK && !(req_acc && req_last_byte),
      err_ff == $past(err_ff), "error code changed within packet")
   `OIHP_ASSERT_NOW(a_map_bound, clock, reset, 1'b1, map_cnt_ff <= channel_ff,
      "map counter ran past channel count")

endmodule

FILE: tb/opus_id_header_parser_test.sv
// ----------------------------------------------------------------------------
// Opus ID header parser testbench
// Feeds whole and broken identification headers one byte per transaction,
// predicts every map entry and summary in the bench, and compares each
// accepted result field by field while both sides idle and stall at random.
// ----------------------------------------------------------------------------
module opus_id_header_parser_test;
   timeunit 1ns;
   timeprecision 1ps;

   import opus_ihp_pkg::*;

   localparam int          NONE         = -1;
   localparam int          CYCLE_LIMIT  = 1000000;
   localparam int          HOLD_CYCLES  = 300;
   localparam int          PHASE_BYTES  = 25;
   localparam int          SETTLE       = 8;
   localparam int          PRINT_CAP    = 100;
   localparam logic [63:0] OPUS_MAGIC   = "OpusHead";

   typedef struct packed {
      logic [7:0]  version;
      logic [7:0]  channels;
      logic [15:0] preskip;
      logic [31:0] rate;
      logic [15:0] gain;
      logic [7:0]  family;
      logic [7:0]  streams;
      logic [7:0]  coupled;
      logic [7:0]  map_val;
      logic        map_rand;
      int          bad_at;
      int          cut;
      int          extra;
      int          flip_pos;
      logic        pinned;
      status_type  want;
   } packet_spec;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = 8'd0;
   logic        req_last_byte = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_kind;
   logic [3:0]  rsp_status;
   logic [7:0]  rsp_version;
   logic [7:0]  rsp_channels;
   logic [15:0] rsp_preskip;
   logic [31:0] rsp_sample_rate;
   logic [15:0] rsp_gain;
   logic [7:0]  rsp_mapping_family;
   logic [7:0]  rsp_stream_count;
   logic [7:0]  rsp_coupled_count;
   logic [7:0]  rsp_map_index;
   logic [7:0]  rsp_map_value;

   // shadow of the offered transaction: a typed summary status where pinned
   logic        cur_pinned = 1'b0;
   status_type  cur_want = ST_OK;

   // parser state held by the bench
   logic [15:0] pos;
   status_type  err;
   logic [7:0]  hdr_version;
   logic [7:0]  hdr_channels;
   logic [15:0] hdr_preskip;
   logic [31:0] hdr_rate;
   logic [15:0] hdr_gain;
   logic [7:0]  hdr_family;
   logic [7:0]  hdr_streams;
   logic [7:0]  hdr_coupled;
   logic [7:0]  map_seen;

   result_type  expected_results[$];
   packet_spec  directed[$];
   logic [7:0]  packet_bytes[$];

   int          idle_pct = 0;
   int          stall_pct = 0;
   bit          hold_go = 1'b0;
   int          hold_left = 0;
   int          cycle_count = 0;
   int          error_count = 0;
   int          bytes_sent = 0;
   int          packets_sent = 0;
   int          maps_checked = 0;
   int          summaries_checked = 0;
   logic [15:0] status_seen = '0;

   opus_id_header_parser uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_data_byte      (req_data_byte),
      .req_last_byte      (req_last_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_kind           (rsp_kind),
      .rsp_status         (rsp_status),
      .rsp_version        (rsp_version),
      .rsp_channels       (rsp_channels),
      .rsp_preskip        (rsp_preskip),
      .rsp_sample_rate    (rsp_sample_rate),
      .rsp_gain           (rsp_gain),
      .rsp_mapping_family (rsp_mapping_family),
      .rsp_stream_count   (rsp_stream_count),
      .rsp_coupled_count  (rsp_coupled_count),
      .rsp_map_index      (rsp_map_index),
      .rsp_map_value      (rsp_map_value)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      error_count++;
      if (error_count <= PRINT_CAP)
         $display("%0t: %s: got %0h, want %0h", $realtime, what, got, want);
   endtask

   task automatic clear_parse();
      pos          = '0;
      err          = ST_OK;
      hdr_version  = '0;
      hdr_channels = '0;
      hdr_preskip  = '0;
      hdr_rate     = '0;
      hdr_gain     = '0;
      hdr_family   = '0;
      hdr_streams  = '0;
      hdr_coupled  = '0;
      map_seen     = '0;
   endtask

   function automatic result_type make_result(kind_type k, status_type st,
                                              logic [7:0] idx, logic [7:0] val);
      result_type r;
      r.kind           = k;
      r.status         = st;
      r.version        = hdr_version;
      r.channels       = hdr_channels;
      r.preskip        = hdr_preskip;
      r.sample_rate    = hdr_rate;
      r.gain           = hdr_gain;
      r.mapping_family = hdr_family;
      r.stream_count   = hdr_streams;
      r.coupled_count  = hdr_coupled;
      r.map_index      = idx;
      r.map_value      = val;
      return r;
   endfunction

   task automatic mark_trailing();
      if (hdr_version == 8'd0 || hdr_version == 8'd1)
         err = ST_TRAILING;
   endtask

   // advance the header parse by one byte and queue what it yields
   task automatic parse_byte(input logic [7:0] b, input logic last,
                             input logic pinned, input status_type want);
      logic [8:0] limit;
      logic       done;
      status_type st;
      if (err == ST_OK) begin
         if (pos < 16'd8) begin
            if (b != OPUS_MAGIC[8 * (7 - pos[2:0]) +: 8])
               err = ST_MAGIC;
         end else if (pos == 16'd8) begin
            hdr_version = b;
            if ((b & MAJOR_MASK) != 8'd0)
               err = ST_VERSION;
         end else if (pos == 16'd9) begin
            hdr_channels = b;
            if (b == 8'd0)
               err = ST_ZERO_CH;
         end else if (pos < 16'd12) begin
            hdr_preskip[8 * (pos - 10) +: 8] = b;
         end else if (pos < 16'd16) begin
            hdr_rate[8 * (pos - 12) +: 8] = b;
         end else if (pos < 16'd18) begin
            hdr_gain[8 * (pos - 16) +: 8] = b;
         end else if (pos == 16'd18) begin
            hdr_family = b;
            if (b == 8'd0) begin
               if (hdr_channels > 8'd2)
                  err = ST_FAM0_CH;
               hdr_streams = 8'd1;
               hdr_coupled = (hdr_channels > 8'd1) ? 8'd1 : 8'd0;
            end
         end else if (hdr_family == 8'd0) begin
            mark_trailing();
         end else if (pos == 16'd19) begin
            hdr_streams = b;
            if (b == 8'd0)
               err = ST_STREAMS;
         end else if (pos == 16'd20) begin
            hdr_coupled = b;
            if (b > hdr_streams || ({1'b0, b} + {1'b0, hdr_streams}) > MAX_SUM)
               err = ST_COUPLED;
         end else if (map_seen < hdr_channels) begin
            limit = {1'b0, hdr_streams} + {1'b0, hdr_coupled};
            if ({1'b0, b} > limit && b != MAP_UNUSED)
               err = ST_MAP;
            expected_results.push_back(make_result(KIND_MAP, err, map_seen, b));
            map_seen++;
         end else begin
            mark_trailing();
         end
      end
      if (pos != 16'hFFFF)
         pos++;
      if (last) begin
         done = pos >= MIN_HEADER_LEN &&
                (hdr_family == 8'd0 || (pos >= MAP_HEADER_LEN && map_seen == hdr_channels));
         st = err;
         if (st == ST_OK && !done)
            st = ST_TRUNC;
         if (pinned)
            st = want;
         expected_results.push_back(make_result(KIND_SUMMARY, st, 8'd0, 8'd0));
         clear_parse();
      end
   endtask

   // check the result side, then track the byte taken at the same edge
   always @(posedge clock) begin : monitor
      result_type want;
      if (reset) begin
         clear_parse();
         expected_results.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               report_mismatch("result with nothing expected", rsp_status, '0);
            end else begin
               want = expected_results.pop_front();
               if (rsp_kind !== want.kind)
                  report_mismatch("kind", rsp_kind, want.kind);
               if (rsp_status !== want.status)
                  report_mismatch("status", rsp_status, want.status);
               if (rsp_version !== want.version)
                  report_mismatch("version", rsp_version, want.version);
               if (rsp_channels !== want.channels)
                  report_mismatch("channels", rsp_channels, want.channels);
               if (rsp_preskip !== want.preskip)
                  report_mismatch("preskip", rsp_preskip, want.preskip);
               if (rsp_sample_rate !== want.sample_rate)
                  report_mismatch("sample_rate", rsp_sample_rate, want.sample_rate);
               if (rsp_gain !== want.gain)
                  report_mismatch("gain", rsp_gain, want.gain);
               if (rsp_mapping_family !== want.mapping_family)
                  report_mismatch("mapping_family", rsp_mapping_family,
                                  want.mapping_family);
               if (rsp_stream_count !== want.stream_count)
                  report_mismatch("stream_count", rsp_stream_count, want.stream_count);
               if (rsp_coupled_count !== want.coupled_count)
                  report_mismatch("coupled_count", rsp_coupled_count, want.coupled_count);
               if (rsp_map_index !== want.map_index)
                  report_mismatch("map_index", rsp_map_index, want.map_index);
               if (rsp_map_value !== want.map_value)
                  report_mismatch("map_value", rsp_map_value, want.map_value);
               if (want.kind == KIND_SUMMARY) begin
                  summaries_checked++;
                  status_seen[want.status] = 1'b1;
               end else begin
                  maps_checked++;
               end
            end
         end
         if (req_valid && !req_stall)
            parse_byte(req_data_byte, req_last_byte, cur_pinned, cur_want);
      end
   end

   // receiver: random stall, or a long hold-off when one is requested
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_go) begin
         hold_go = 1'b0;
         hold_left = HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout at cycle %0d with %0d results outstanding",
                  cycle_count, expected_results.size());
         $display("opus_id_header_parser_test: errors");
         $finish;
      end
   end

   function automatic packet_spec row(int ver, int ch, int fam, int st, int cp, int mv,
                                      int bad, int cut, int extra, int flip,
                                      bit pinned, status_type want);
      packet_spec s;
      s.version  = 8'(ver);
      s.channels = 8'(ch);
      s.preskip  = 16'($urandom);
      s.rate     = $urandom;
      s.gain     = 16'($urandom);
      s.family   = 8'(fam);
      s.streams  = 8'(st);
      s.coupled  = 8'(cp);
      s.map_val  = 8'(mv);
      s.map_rand = 1'b0;
      s.bad_at   = bad;
      s.cut      = cut;
      s.extra    = extra;
      s.flip_pos = flip;
      s.pinned   = pinned;
      s.want     = want;
      return s;
   endfunction

   // mostly well-formed headers with random content, the rest flawed
   function automatic packet_spec random_spec();
      packet_spec s;
      int         pick;
      int         flaw;
      s = row(0, 1, 0, 0, 0, 0, NONE, 0, 0, NONE, 1'b0, ST_OK);
      pick = $urandom_range(9);
      s.version = (pick < 5) ? 8'd0 : (pick < 8) ? 8'd1 : 8'($urandom_range(2, 15));
      if (s.version > 8'd1 && $urandom_range(3) == 0)
         s.extra = $urandom_range(1, 5);
      pick = $urandom_range(99);
      if (pick < 40) begin
         s.channels = 8'($urandom_range(1, 2));
      end else begin
         s.family   = 8'($urandom_range(1, 255));
         s.channels = (pick < 90) ? 8'($urandom_range(1, 8)) : 8'($urandom_range(9, 40));
         s.streams  = 8'($urandom_range(1, 6));
         s.coupled  = 8'($urandom_range(0, s.streams));
         s.map_rand = 1'b1;
      end
      flaw = $urandom_range(99);
      if (flaw >= 75) begin
         case (flaw % 8)
            0: s.cut = $urandom_range(1, 24);
            1: s.flip_pos = $urandom_range(0, 20);
            2: s.version = 8'($urandom_range(16, 255));
            3: s.extra = $urandom_range(1, 3);
            4: s.channels = (s.family == 8'd0) ? 8'($urandom_range(3, 255)) : 8'd0;
            5: s.streams = 8'd0;
            6: s.coupled = 8'($urandom_range(s.streams + 1, 255));
            default: s.bad_at = $urandom_range(0, s.channels - 1);
         endcase
      end
      return s;
   endfunction

   function automatic packet_spec wide_spec();
      packet_spec s;
      s = row(0, 8, 1, 4, 4, 0, NONE, 0, 0, NONE, 1'b0, ST_OK);
      s.map_rand = 1'b1;
      return s;
   endfunction

   task automatic build_packet(input packet_spec s);
      logic [8:0] limit;
      logic [7:0] val;
      logic [7:0] junk;
      packet_bytes.delete();
      for (int i = 0; i < 8; i++)
         packet_bytes.push_back(OPUS_MAGIC[8 * (7 - i) +: 8]);
      packet_bytes.push_back(s.version);
      packet_bytes.push_back(s.channels);
      packet_bytes.push_back(s.preskip[7:0]);
      packet_bytes.push_back(s.preskip[15:8]);
      for (int i = 0; i < 4; i++)
         packet_bytes.push_back(s.rate[8 * i +: 8]);
      packet_bytes.push_back(s.gain[7:0]);
      packet_bytes.push_back(s.gain[15:8]);
      packet_bytes.push_back(s.family);
      if (s.family != 8'd0) begin
         packet_bytes.push_back(s.streams);
         packet_bytes.push_back(s.coupled);
         limit = {1'b0, s.streams} + {1'b0, s.coupled};
         for (int i = 0; i < s.channels; i++) begin
            val = s.map_val;
            if (s.map_rand) begin
               case ($urandom_range(9))
                  0:       val = MAP_UNUSED;
                  1:       val = 8'($urandom_range(255));
                  default: val = 8'($urandom_range(0, (limit > 9'd255) ? 255 : limit));
               endcase
            end
            if (i == s.bad_at)
               val = 8'(limit + 9'd1);
            packet_bytes.push_back(val);
         end
      end
      for (int i = 0; i < s.extra; i++)
         packet_bytes.push_back(8'($urandom_range(255)));
      if (s.cut > 0) begin
         while (packet_bytes.size() > s.cut)
            junk = packet_bytes.pop_back();
      end
      if (s.flip_pos >= 0 && s.flip_pos < packet_bytes.size())
         packet_bytes[s.flip_pos] = packet_bytes[s.flip_pos] ^ 8'hFF;
   endtask

   // offer one transaction after a random gap, hold it until taken
   task automatic send_byte(input logic [7:0] b, input logic last, input logic pinned,
                            input status_type want);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= b;
      req_last_byte <= last;
      cur_pinned    <= pinned;
      cur_want      <= want;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      bytes_sent++;
   endtask

   task automatic send_packet(input packet_spec s);
      build_packet(s);
      for (int i = 0; i < packet_bytes.size(); i++)
         send_byte(packet_bytes[i], i == packet_bytes.size() - 1, s.pinned, s.want);
      packets_sent++;
   endtask

   // short run of loose bytes, mostly failing the magic check
   task automatic send_noise();
      int         n;
      logic [7:0] b;
      n = $urandom_range(1, 12);
      for (int i = 0; i < n; i++) begin
         b = (i == 0 && $urandom_range(3) == 0) ? OPUS_MAGIC[63:56] : 8'($urandom_range(255));
         send_byte(b, i == n - 1, 1'b0, ST_OK);
      end
      packets_sent++;
   endtask

   // let the last transaction reach the monitor first, so it has queued what it yields
   task automatic wait_for_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_results.size() != 0)
         @(posedge clock);
   endtask

   task automatic run_phase(input int idle, input int stall, input bit hold);
      int start;
      idle_pct  = idle;
      stall_pct = stall;
      if (hold) begin
         // hold the receiver while wide maps fill the result queue
         hold_go = 1'b1;
         for (int i = 0; i < 4; i++)
            send_packet(wide_spec());
      end
      start = bytes_sent;
      while (bytes_sent - start < PHASE_BYTES) begin
         if ($urandom_range(9) == 0)
            send_noise();
         else
            send_packet(random_spec());
      end
      wait_for_results();
   endtask

   initial begin
      packet_spec ext;

      //                    ver  ch  fam  st   cp   mv   bad   cut ext    flip pin want
      directed.push_back(row(0,   1,  0,   0,   0,   0,   NONE, 1,  0,     NONE, 1, ST_TRUNC));
      directed.push_back(row(0,   1,  0,   0,   0,   0,   NONE, 1,  0,     0,    1, ST_MAGIC));
      directed.push_back(row(0,   2,  0,   0,   0,   0,   NONE, 0,  0,     7,    1, ST_MAGIC));
      directed.push_back(row('h10, 2, 0,   0,   0,   0,   NONE, 0,  0,     NONE, 1, ST_VERSION));
      directed.push_back(row('hFF, 2, 0,   0,   0,   0,   NONE, 0,  0,     NONE, 1, ST_VERSION));
      directed.push_back(row('h10, 0, 0,   0,   0,   0,   NONE, 0,  0,     NONE, 1, ST_VERSION));
      directed.push_back(row(0,   0,  0,   0,   0,   0,   NONE, 0,  0,     NONE, 1, ST_ZERO_CH));
      directed.push_back(row(0,   3,  0,   0,   0,   0,   NONE, 0,  0,     NONE, 1, ST_FAM0_CH));
      directed.push_back(row(0,   3,  0,   0,   0,   0,   NONE, 0,  2,     NONE, 1, ST_FAM0_CH));
      directed.push_back(row(0,   2,  0,   0,   0,   0,   NONE, 0,  1,     NONE, 1, ST_TRAILING));
      directed.push_back(row(1,   1,  0,   0,   0,   0,   NONE, 0,  1,     NONE, 1, ST_TRAILING));
      directed.push_back(row('h0F, 2, 0,   0,   0,   0,   NONE, 0,  3,     NONE, 0, ST_OK));
      directed.push_back(row(0,   2,  0,   0,   0,   0,   NONE, 18, 0,     NONE, 1, ST_TRUNC));
      directed.push_back(row(0,   2,  1,   0,   0,   0,   NONE, 19, 0,     NONE, 1, ST_TRUNC));
      directed.push_back(row(0,   2,  1,   0,   0,   0,   NONE, 0,  0,     NONE, 1, ST_STREAMS));
      directed.push_back(row(0,   2,  1,   1,   2,   0,   NONE, 0,  0,     NONE, 1, ST_COUPLED));
      directed.push_back(row(0,   3,  255, 200, 100, 0,   NONE, 0,  0,     NONE, 1, ST_COUPLED));
      directed.push_back(row(0,   2,  1,   2,   1,   3,   NONE, 0,  0,     NONE, 0, ST_OK));
      directed.push_back(row(0,   3,  1,   2,   1,   0,   0,    0,  0,     NONE, 1, ST_MAP));
      directed.push_back(row(0,   3,  1,   2,   1,   2,   2,    0,  0,     NONE, 1, ST_MAP));
      directed.push_back(row(0,   2,  1,   1,   1,   2,   1,    0,  1,     NONE, 1, ST_MAP));
      directed.push_back(row(0,   4,  1,   1,   0,   255, NONE, 0,  0,     NONE, 0, ST_OK));
      directed.push_back(row(0,   1,  3,   255, 0,   255, NONE, 0,  0,     NONE, 0, ST_OK));
      directed.push_back(row(0,   255, 2,  128, 127, 255, NONE, 0,  0,     NONE, 0, ST_OK));
      directed.push_back(row(0,   3,  1,   1,   0,   0,   NONE, 22, 0,     NONE, 1, ST_TRUNC));
      directed.push_back(row(1,   2,  1,   2,   0,   0,   NONE, 0,  2,     NONE, 1, ST_TRAILING));
      ext = row(0, 1, 0, 0, 0, 0, NONE, 0, 0, NONE, 1, ST_OK);
      ext.preskip = '0;
      ext.rate    = '0;
      ext.gain    = '0;
      directed.push_back(ext);
      ext = row(1, 2, 0, 0, 0, 0, NONE, 0, 0, NONE, 1, ST_OK);
      ext.preskip = '1;
      ext.rate    = '1;
      ext.gain    = '1;
      directed.push_back(ext);

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (directed[i])
         send_packet(directed[i]);
      wait_for_results();

      run_phase(0, 0, 1'b1);
      run_phase(85, 0, 1'b0);
      run_phase(0, 85, 1'b0);
      run_phase(9, 9, 1'b0);

      wait_for_results();
      repeat (SETTLE) @(posedge clock);

      if (expected_results.size() != 0)
         report_mismatch("results never produced", 32'(expected_results.size()), '0);

      $display("ran %0d packets, %0d bytes; checked %0d map entries and %0d summaries",
               packets_sent, bytes_sent, maps_checked, summaries_checked);
      $display("summary status codes seen, one bit per code: %b", status_seen);
      if (error_count == 0)
         $display("opus_id_header_parser_test: clean");
      else
         $display("opus_id_header_parser_test: errors");
      $finish;
   end

endmodule
